// ===== hw/rtl/cwm_pkg.sv =====
// ----------------------------------------------------------------------------
// cwm_pkg: shared types and constants for the cylindrical warp map
// Widths, fixed-point formats, CORDIC arctangent table and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package cwm_pkg;

    localparam int COORD_BITS      = 12;
    localparam int ANGLE_FRAC_BITS = 16;
    localparam int WORK_FRAC       = 30;
    localparam int CORDIC_STEPS    = 30;

    // datapath widths
    localparam int FOCAL_BITS = 12;
    localparam int DIM_BITS   = 13;
    localparam int CW         = 34;          // CORDIC x, y, z (signed, Q30)
    localparam int DIV_QBITS  = 18;          // quotient bits before overflow
    localparam int DIV_NBITS  = 46;          // dividend
    localparam int DIV_DBITS  = 33;          // divisor
    localparam int DIV_LAT    = DIV_QBITS + 1;
    localparam int POS_BITS   = 20;          // signed source position

    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint CORDIC_GAIN = 64'sd652032874;
    localparam int     ANG_SHIFT   = WORK_FRAC - ANGLE_FRAC_BITS;
    localparam longint HALF_PI_Q   =
        (HALF_PI_Q30 + (64'sd1 <<< (ANG_SHIFT - 1))) >>> ANG_SHIFT;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_FOCAL  = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2
    } cfg_idx_t;

    // arctan(2^-i) in Q30
    function automatic logic signed [CW-1:0] atan_q30(input int i);
        logic signed [CW-1:0] v;
        begin
            case (i)
                0:  v = CW'(843314856);
                1:  v = CW'(497837829);
                2:  v = CW'(263043836);
                3:  v = CW'(133525158);
                4:  v = CW'(67021686);
                5:  v = CW'(33543515);
                6:  v = CW'(16771754);
                7:  v = CW'(8388437);
                8:  v = CW'(4194282);
                9:  v = CW'(2097149);
                10: v = CW'(1048575);
                11: v = CW'(524287);
                12: v = CW'(262143);
                13: v = CW'(131071);
                14: v = CW'(65535);
                15: v = CW'(32767);
                16: v = CW'(16383);
                17: v = CW'(8191);
                18: v = CW'(4095);
                19: v = CW'(2047);
                20: v = CW'(1023);
                21: v = CW'(511);
                22: v = CW'(255);
                23: v = CW'(127);
                24: v = CW'(63);
                25: v = CW'(31);
                26: v = CW'(15);
                27: v = CW'(7);
                28: v = CW'(3);
                29: v = CW'(1);
                default: v = '0;
            endcase
            return v;
        end
    endfunction

    // per-item side information carried down the pipeline
    typedef struct packed {
        logic                  dx_neg;
        logic                  dy_neg;
        logic [COORD_BITS-1:0] dy_mag;
        logic                  cy_neg;
        logic                  bad;
    } cwm_side_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cwm_div.sv =====
// ----------------------------------------------------------------------------
// cwm_div: pipelined restoring divider
// One quotient bit per stage; flags quotients that do not fit DIV_QBITS.
// ----------------------------------------------------------------------------
`default_nettype none

module cwm_div
    import cwm_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 en,
    input  wire logic [DIV_NBITS-1:0] num,
    input  wire logic [DIV_DBITS-1:0] den,
    output logic      [DIV_QBITS-1:0] quo,
    output logic                      ovf
);

    localparam int WW = DIV_DBITS + DIV_QBITS;

    logic [WW-1:0]        rem_reg [0:DIV_QBITS];
    logic [DIV_DBITS-1:0] den_reg [0:DIV_QBITS];
    logic [DIV_QBITS-1:0] quo_reg [0:DIV_QBITS];
    logic                 ovf_reg [0:DIV_QBITS];

    // entry: overflow when num >= den * 2^QBITS
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= WW'(num);
            den_reg[0] <= den;
            quo_reg[0] <= '0;
            ovf_reg[0] <= (WW'(num) >= {den, {DIV_QBITS{1'b0}}});
        end
    end

    // one trial subtraction per stage, most significant bit first
    for (genvar k = 0; k < DIV_QBITS; k++)
    begin : g_stage
        localparam int SH = DIV_QBITS - 1 - k;
        logic [WW-1:0] dsh;
        logic          take;
        logic [WW-1:0] rem_next;

        assign dsh      = WW'(den_reg[k]) << SH;
        assign take     = (rem_reg[k] >= dsh);
        assign rem_next = take ? (rem_reg[k] - dsh) : rem_reg[k];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= rem_next;
                den_reg[k+1] <= den_reg[k];
                quo_reg[k+1] <= quo_reg[k] | (take ? (DIV_QBITS'(1) << SH) : '0);
                ovf_reg[k+1] <= ovf_reg[k];
            end
        end
    end

    assign quo = quo_reg[DIV_QBITS];
    assign ovf = ovf_reg[DIV_QBITS];

endmodule

`default_nettype wire

// ===== hw/rtl/cwm_cordic.sv =====
// ----------------------------------------------------------------------------
// cwm_cordic: pipelined rotation-mode CORDIC
// Gives cos and sin of a Q30 angle in Q30, one rotation per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module cwm_cordic
    import cwm_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 en,
    input  wire logic signed [CW-1:0] ang,
    output logic signed      [CW-1:0] cos_q,
    output logic signed      [CW-1:0] sin_q
);

    logic signed [CW-1:0] x_reg [0:CORDIC_STEPS];
    logic signed [CW-1:0] y_reg [0:CORDIC_STEPS];
    logic signed [CW-1:0] z_reg [0:CORDIC_STEPS];

    // start vector pre-scaled by the gain
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= CW'(CORDIC_GAIN);
            y_reg[0] <= '0;
            z_reg[0] <= ang;
        end
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_rot
        localparam logic signed [CW-1:0] AT = atan_q30(k);
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        logic                 up;

        assign xs = x_reg[k] >>> k;
        assign ys = y_reg[k] >>> k;
        assign up = ~z_reg[k][CW-1];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[k+1] <= up ? (x_reg[k] - ys) : (x_reg[k] + ys);
                y_reg[k+1] <= up ? (y_reg[k] + xs) : (y_reg[k] - xs);
                z_reg[k+1] <= up ? (z_reg[k] - AT) : (z_reg[k] + AT);
            end
        end
    end

    assign cos_q = x_reg[CORDIC_STEPS];
    assign sin_q = y_reg[CORDIC_STEPS];

endmodule

`default_nettype wire

// ===== hw/rtl/cylindrical_warp_coordinate_map.sv =====
// ----------------------------------------------------------------------------
// cylindrical_warp_coordinate_map: inverse cylindrical projection addresses
// Maps each output pixel coordinate to its source pixel coordinate.
// ----------------------------------------------------------------------------
// Usage
//   s_axis carries one output pixel coordinate per transfer, m_axis returns
//   the matching source coordinate, with tuser high when it lies inside the
//   image (both coordinates read 0 otherwise).
//   cfg writes focal length, width and height; cfg_ready is always high.
//   The user must write registers only while no coordinate is in flight; the block does not enforce this.
//   The path holds 73 register stages: an 18-bit angle divider (19 stages),
//   a 30-step CORDIC (31 stages), a multiplier stage and two 18-bit offset
//   dividers (19 stages) plus glue registers.
//   Throughput is one coordinate per cycle while the output is not stalled; every stage is registered.
//   The whole pipeline advances together, so s_axis_tready drops only while
//   a result sits at the output and m_axis_tready is low; nothing is lost or
//   repeated across a stall.
//   Reset clears every valid bit and loads 500 / 640 / 480 into the
//   registers; the output is idle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module cylindrical_warp_coordinate_map
    import cwm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [12:0] cfg_data,
    // input coordinate
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // [11:0] out_x, [23:12] out_y
    // source coordinate
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [11:0] src_x, [23:12] src_y
    output logic [0:0]       m_axis_tuser    // [0] in_range
);

    localparam int S_T  = 2 + DIV_LAT;              // angle checked
    localparam int S_CO = S_T + CORDIC_STEPS + 1;   // cos / sin ready
    localparam int S_M  = S_CO + 1;                 // product registered
    localparam int L    = S_M + DIV_LAT + 1;        // output register

    // configuration registers
    logic [FOCAL_BITS-1:0] focal_reg;
    logic [DIM_BITS-1:0]   width_reg;
    logic [DIM_BITS-1:0]   height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_reg  <= FOCAL_BITS'(500);
            width_reg  <= DIM_BITS'(640);
            height_reg <= DIM_BITS'(480);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_FOCAL:  focal_reg  <= cfg_data[FOCAL_BITS-1:0];
                CFG_WIDTH:  width_reg  <= cfg_data;
                CFG_HEIGHT: height_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    logic [FOCAL_BITS-1:0] f_eff;
    logic [COORD_BITS-1:0] xc;
    logic [COORD_BITS-1:0] yc;

    assign f_eff = (focal_reg == '0) ? FOCAL_BITS'(1) : focal_reg;
    assign xc    = width_reg[DIM_BITS-1:1];
    assign yc    = height_reg[DIM_BITS-1:1];

    // pipeline advance
    logic           en;
    logic           vld_reg [1:L];
    cwm_side_t      sb_reg  [1:L];

    assign en            = !vld_reg[L] || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= L; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[1] <= s_axis_tvalid;
            for (int k = 2; k <= L; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // stage 1: offsets from the centre
    logic [COORD_BITS-1:0] in_x;
    logic [COORD_BITS-1:0] in_y;
    logic                  dx_neg_next;
    logic                  dy_neg_next;
    logic [COORD_BITS-1:0] dxm_next;
    logic [COORD_BITS-1:0] dym_next;
    logic [COORD_BITS-1:0] dxm_reg;

    assign in_x        = s_axis_tdata[11:0];
    assign in_y        = s_axis_tdata[23:12];
    assign dx_neg_next = (in_x < xc);
    assign dy_neg_next = (in_y < yc);
    assign dxm_next    = dx_neg_next ? (xc - in_x) : (in_x - xc);
    assign dym_next    = dy_neg_next ? (yc - in_y) : (in_y - yc);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dxm_reg       <= dxm_next;
            sb_reg[1]     <= '{dx_neg: dx_neg_next, dy_neg: dy_neg_next,
                               dy_mag: dym_next, cy_neg: 1'b0, bad: 1'b0};
        end
    end

    // angle divider: theta = round(dx * 2^16 / f)
    logic [DIV_NBITS-1:0] th_num;
    logic [DIV_DBITS-1:0] th_den;
    logic [DIV_QBITS-1:0] th_q;
    logic                 th_ovf;

    assign th_num = DIV_NBITS'({dxm_reg, {(ANGLE_FRAC_BITS + 1){1'b0}}})
                  + DIV_NBITS'(f_eff);
    assign th_den = DIV_DBITS'({f_eff, 1'b0});

    cwm_div u_div_theta (
        .clk (clk),
        .en  (en),
        .num (th_num),
        .den (th_den),
        .quo (th_q),
        .ovf (th_ovf)
    );

    // angle check and move to Q30
    logic                 th_bad;
    logic signed [CW-1:0] z_mag;
    logic signed [CW-1:0] z_reg;

    assign th_bad = th_ovf || (CW'(th_q) >= CW'(HALF_PI_Q));
    assign z_mag  = CW'(th_q) <<< ANG_SHIFT;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z_reg <= sb_reg[S_T-1].dx_neg ? -z_mag : z_mag;
        end
    end

    logic signed [CW-1:0] cos_q;
    logic signed [CW-1:0] sin_q;

    cwm_cordic u_cordic (
        .clk   (clk),
        .en    (en),
        .ang   (z_reg),
        .cos_q (cos_q),
        .sin_q (sin_q)
    );

    // f * |sin| product
    localparam int PW = FOCAL_BITS + CW - 1;
    logic [CW-2:0]        sin_mag;
    logic [PW-1:0]        prod_reg;
    logic [DIV_DBITS-2:0] cx_reg;

    assign sin_mag = sin_q[CW-1] ? (CW-1)'(-sin_q) : sin_q[CW-2:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= PW'(f_eff) * PW'(sin_mag);
            cx_reg   <= cos_q[DIV_DBITS-2:0];
        end
    end

    // side information line, updated where flags are found
    for (genvar k = 2; k <= L; k++)
    begin : g_side
        cwm_side_t side_next;

        always_comb
        begin
            side_next = sb_reg[k-1];
            if (k == S_T)
            begin
                side_next.bad = th_bad;
            end
            if (k == S_M)
            begin
                side_next.bad    = sb_reg[k-1].bad || (cos_q <= 0);
                side_next.cy_neg = sin_q[CW-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sb_reg[k] <= side_next;
            end
        end
    end

    // offset dividers
    logic [DIV_NBITS-1:0] ox_num;
    logic [DIV_NBITS-1:0] oy_num;
    logic [DIV_DBITS-1:0] o_den;
    logic [DIV_QBITS-1:0] qx;
    logic [DIV_QBITS-1:0] qy;
    logic                 ovfx;
    logic                 ovfy;

    assign ox_num = DIV_NBITS'({prod_reg, 1'b0}) + DIV_NBITS'(cx_reg);
    assign oy_num = DIV_NBITS'({sb_reg[S_M].dy_mag, {(WORK_FRAC + 1){1'b0}}})
                  + DIV_NBITS'(cx_reg);
    assign o_den  = {cx_reg, 1'b0};

    cwm_div u_div_x (
        .clk (clk),
        .en  (en),
        .num (ox_num),
        .den (o_den),
        .quo (qx),
        .ovf (ovfx)
    );

    cwm_div u_div_y (
        .clk (clk),
        .en  (en),
        .num (oy_num),
        .den (o_den),
        .quo (qy),
        .ovf (ovfy)
    );

    // final position and bounds check
    logic signed [POS_BITS-1:0] offx;
    logic signed [POS_BITS-1:0] offy;
    logic signed [POS_BITS-1:0] sx;
    logic signed [POS_BITS-1:0] sy;
    logic                       ok;
    logic [COORD_BITS-1:0]      src_x_reg;
    logic [COORD_BITS-1:0]      src_y_reg;
    logic                       rng_reg;

    assign offx = sb_reg[L-1].cy_neg ? -POS_BITS'(qx) : POS_BITS'(qx);
    assign offy = sb_reg[L-1].dy_neg ? -POS_BITS'(qy) : POS_BITS'(qy);
    assign sx   = offx + POS_BITS'(xc);
    assign sy   = offy + POS_BITS'(yc);
    assign ok   = !sb_reg[L-1].bad && !ovfx && !ovfy
               && (sx >= 0) && (sx < POS_BITS'(width_reg))
               && (sx < POS_BITS'(1 << COORD_BITS))
               && (sy >= 0) && (sy < POS_BITS'(height_reg))
               && (sy < POS_BITS'(1 << COORD_BITS));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            src_x_reg <= ok ? sx[COORD_BITS-1:0] : '0;
            src_y_reg <= ok ? sy[COORD_BITS-1:0] : '0;
            rng_reg   <= ok;
        end
    end

    assign m_axis_tvalid = vld_reg[L];
    assign m_axis_tdata  = {src_y_reg, src_x_reg};
    assign m_axis_tuser  = rng_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/cwm_checker.sv =====
// ----------------------------------------------------------------------------
// cwm_checker: port-level checks for the cylindrical warp map
// Watches the stream and configuration ports of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cwm_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        cfg_ready,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [23:0] m_axis_tdata,
    input wire logic [0:0]  m_axis_tuser
);

    // a waiting result stays until its transfer
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed while stalled");

    // out-of-range results carry zero coordinates
    a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 24'd0)
        else $error("out-of-range result with non-zero coordinates");

    // input side stalls exactly when the output is blocked
    a_backpress: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output stall");

    // configuration is always taken
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration channel not ready");

endmodule

bind cylindrical_warp_coordinate_map cwm_checker u_cwm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_ready     (cfg_ready),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
